[hw/rtl/pse_pkg.sv]
// shared types and constants for the prime sieve engine
// no dependencies; imported by the core and its checker
`default_nettype none

package pse_pkg;

  // fixed field widths
  localparam int NUM_W  = 16;
  localparam int RANK_W = 13;

  // parameter defaults
  localparam int MAX_LIMIT_DEF   = 65535;
  localparam int PRIME_SLOTS_DEF = 8192;

  // largest limit the 16-bit register can ask for
  localparam int LIMIT_CAP = (2 ** NUM_W) - 1;

  // sieve_limit after reset
  localparam logic [NUM_W-1:0] SIEVE_LIMIT_RST = NUM_W'(LIMIT_CAP);

  // action codes
  localparam logic ACT_BUILD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // input item
  typedef struct packed {
    logic              action;
    logic [NUM_W-1:0]  query_number;
    logic [RANK_W-1:0] query_rank;
  } pse_in_t;

  // result item
  typedef struct packed {
    logic              is_prime;
    logic [NUM_W-1:0]  ranked_prime;
    logic [RANK_W-1:0] prime_total;
    logic              number_valid;
    logic              rank_valid;
  } pse_out_t;

endpackage

`default_nettype wire

[hw/rtl/prime_sieve_engine_core.sv]
// prime sieve engine: sieve of eratosthenes with a ranked prime list
// depends on pse_pkg; checked by pse_checker (bound in its own file)
//
// Usage: in_data carries one item per transfer. A build item (action 0) sieves
// 0..min(sieve_limit, MAX_LIMIT) into a one-bit flag memory and lists the primes
// by rank; a query item (action 1) returns primality of query_number, the prime
// of query_rank and the prime count, with validity flags. Every item gives one
// result on out_data. sieve_limit is written through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Sequence: a query reads the flag and table memories, then loads the output
// register, and the sequencer returns to idle as out_valid rises, so the next
// item can transfer in that same cycle. A build fills the flags, scans the
// candidates and crosses out the multiples of each prime found, then loads the
// count; every step goes through the flag memory and one shared adder/comparator.
// in_ready is high only while the sequencer is idle.
// Reset (synchronous, rst_n low) clears the count, the built limit and the
// built flag; the flag and prime memories are not cleared, a build writes them.
// When the receiver stalls, the finished result holds in the output register;
// the sequencer returns to idle and the next item waits until the register
// frees up before its result is loaded.
`default_nettype none

module prime_sieve_engine_core #(
  parameter int MAX_LIMIT   = pse_pkg::MAX_LIMIT_DEF,
  parameter int PRIME_SLOTS = pse_pkg::PRIME_SLOTS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  pse_pkg::pse_in_t               in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output pse_pkg::pse_out_t              out_data,
  input  wire                            cfg_we,
  input  wire  [pse_pkg::NUM_W-1:0]      cfg_wdata
);
  import pse_pkg::*;

  localparam int EFF_MAX    = (MAX_LIMIT < LIMIT_CAP) ? MAX_LIMIT : LIMIT_CAP;
  localparam int FLAG_DEPTH = EFF_MAX + 1;
  localparam int FA_W       = $clog2(FLAG_DEPTH);
  localparam int TW         = $clog2(PRIME_SLOTS);
  localparam int CW         = (TW > RANK_W) ? TW : RANK_W;
  localparam int LW         = NUM_W;
  localparam int PW         = LW + 1;
  localparam int DW         = 2 * LW;

  localparam logic [TW-1:0] TALLY_MAX = TW'(PRIME_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SCAN_RD, S_SCAN_CHK, S_CROSS, S_DONE, S_QRY
  } state_t;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   sieve_limit_r;
  logic [LW-1:0]   lim_r, lim_nxt;
  logic [LW-1:0]   built_limit_r, built_limit_nxt;
  logic            table_ready_r, table_ready_nxt;
  logic [TW-1:0]   tally_r, tally_nxt;
  logic [PW-1:0]   ptr_r, ptr_nxt;
  logic [DW-1:0]   m_r, m_nxt;
  logic            nv_r, nv_nxt;
  logic            rv_r, rv_nxt;
  logic            out_valid_r, out_valid_nxt;
  pse_out_t        out_r, out_nxt;

  // memories and their ports
  logic            flag_mem [FLAG_DEPTH];
  logic [NUM_W-1:0] tab_mem [PRIME_SLOTS];
  logic            flag_q_r;
  logic [NUM_W-1:0] tab_q_r;
  logic            flag_we, flag_wd, flag_re;
  logic [FA_W-1:0] flag_wa, flag_ra;
  logic            tab_we, tab_re;
  logic [TW-1:0]   tab_wa, tab_ra;
  logic [NUM_W-1:0] tab_wd;

  // shared adder and comparator
  logic [DW-1:0]   add_a, add_b, sum;
  logic [DW-1:0]   cmp_a;
  logic            gt;

  logic            in_xfer;
  logic            out_free;
  logic [LW-1:0]   eff_limit;
  logic [CW-1:0]   rank_ext, tally_ext;
  logic [DW-1:0]   square;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign eff_limit = (sieve_limit_r > LW'(EFF_MAX)) ? LW'(EFF_MAX) : sieve_limit_r;
  assign rank_ext  = CW'(in_data.query_rank);
  assign tally_ext = CW'(tally_r);
  assign square    = DW'(ptr_r[LW-1:0]) * DW'(ptr_r[LW-1:0]);

  // comparator operand: counter or multiple against the active limit
  always_comb begin
    cmp_a = '0;
    unique case (state_r)
      S_INIT, S_SCAN_RD: cmp_a = DW'(ptr_r);
      S_CROSS:           cmp_a = m_r;
      default:           cmp_a = '0;
    endcase
  end

  assign gt = (cmp_a > DW'(lim_r));

  // adder operands per sequencer step
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state_r)
      S_INIT: begin
        add_a = DW'(ptr_r);
        add_b = DW'(1);
      end
      S_SCAN_CHK: begin
        add_a = flag_q_r ? DW'(tally_r) : DW'(ptr_r);
        add_b = DW'(1);
      end
      S_CROSS: begin
        add_a = gt ? DW'(ptr_r) : m_r;
        add_b = gt ? DW'(1) : DW'(ptr_r);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign sum = add_a + add_b;

  // sequencer next state
  always_comb begin
    state_nxt       = state_r;
    lim_nxt         = lim_r;
    built_limit_nxt = built_limit_r;
    table_ready_nxt = table_ready_r;
    tally_nxt       = tally_r;
    ptr_nxt         = ptr_r;
    m_nxt           = m_r;
    nv_nxt          = nv_r;
    rv_nxt          = rv_r;
    out_nxt         = out_r;
    flag_we = 1'b0;
    flag_wa = ptr_r[FA_W-1:0];
    flag_wd = 1'b0;
    flag_re = 1'b0;
    flag_ra = ptr_r[FA_W-1:0];
    tab_we  = 1'b0;
    tab_wa  = sum[TW-1:0];
    tab_wd  = ptr_r[NUM_W-1:0];
    tab_re  = 1'b0;
    tab_ra  = rank_ext[TW-1:0];
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.action == ACT_BUILD) begin
            lim_nxt   = eff_limit;
            ptr_nxt   = '0;
            tally_nxt = '0;
            state_nxt = S_INIT;
          end else begin
            flag_re   = 1'b1;
            flag_ra   = in_data.query_number[FA_W-1:0];
            tab_re    = 1'b1;
            nv_nxt    = table_ready_r && (in_data.query_number <= built_limit_r);
            rv_nxt    = table_ready_r && (rank_ext != '0) && (rank_ext <= tally_ext);
            state_nxt = S_QRY;
          end
        end
      end
      // fill flags: 0 and 1 composite, the rest candidate
      S_INIT: begin
        if (gt) begin
          ptr_nxt   = PW'(2);
          state_nxt = S_SCAN_RD;
        end else begin
          flag_we = 1'b1;
          flag_wd = (ptr_r[PW-1:1] != '0);
          ptr_nxt = sum[PW-1:0];
        end
      end
      S_SCAN_RD: begin
        if (gt) begin
          state_nxt = S_DONE;
        end else begin
          flag_re   = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      // prime found: list it while the table has room and start crossing at its square; else move on
      S_SCAN_CHK: begin
        if (flag_q_r) begin
          if (tally_r < TALLY_MAX) begin
            tally_nxt = sum[TW-1:0];
            tab_we    = 1'b1;
          end
          m_nxt     = square;
          state_nxt = S_CROSS;
        end else begin
          ptr_nxt   = sum[PW-1:0];
          state_nxt = S_SCAN_RD;
        end
      end
      S_CROSS: begin
        if (gt) begin
          ptr_nxt   = sum[PW-1:0];
          state_nxt = S_SCAN_RD;
        end else begin
          flag_we = 1'b1;
          flag_wa = m_r[FA_W-1:0];
          flag_wd = 1'b0;
          m_nxt   = sum;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt              = '0;
          out_nxt.prime_total  = tally_ext[RANK_W-1:0];
          out_valid_nxt        = 1'b1;
          built_limit_nxt      = lim_r;
          table_ready_nxt      = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      S_QRY: begin
        if (out_free) begin
          out_nxt.is_prime     = nv_r && flag_q_r;
          out_nxt.ranked_prime = rv_r ? tab_q_r : '0;
          out_nxt.prime_total  = table_ready_r ? tally_ext[RANK_W-1:0] : '0;
          out_nxt.number_valid = nv_r;
          out_nxt.rank_valid   = rv_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sieve_limit_r <= SIEVE_LIMIT_RST;
      built_limit_r <= '0;
      table_ready_r <= 1'b0;
      tally_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_we) begin
        sieve_limit_r <= cfg_wdata;
      end
      built_limit_r <= built_limit_nxt;
      table_ready_r <= table_ready_nxt;
      tally_r       <= tally_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    ptr_r <= ptr_nxt;
    m_r   <= m_nxt;
    nv_r  <= nv_nxt;
    rv_r  <= rv_nxt;
    out_r <= out_nxt;
  end

  // flag memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    if (flag_re) begin
      flag_q_r <= flag_mem[flag_ra];
    end
  end

  // ranked prime memory
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    if (tab_re) begin
      tab_q_r <= tab_mem[tab_ra];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pse_checker.sv]
// port-level checks for the prime sieve engine core
// depends on pse_pkg; bound to prime_sieve_engine_core below
`default_nettype none

module pse_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input pse_pkg::pse_out_t   out_data
);
  import pse_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: ready drops after an input transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // primality only reported for a valid number
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.number_valid |-> !out_data.is_prime)
    else $error("is_prime without number_valid");

  // ranked prime is zero when invalid and greater than one when valid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.rank_valid ? (out_data.ranked_prime > 16'd1)
                                       : (out_data.ranked_prime == '0)))
    else $error("ranked_prime inconsistent with rank_valid");

endmodule

bind prime_sieve_engine_core pse_checker u_pse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
